// ===== rtl/core/scfp_pkg.sv =====
// Package for the sum-checked frame parser: parser phases, verdict codes,
// register indexes, reset values and the result record. No dependencies.
`timescale 1ns / 1ps

package scfp_pkg;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4,
    PH_TAIL = 3'd5,
    PH_IDLE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FRAME = 2'd1,
    ST_SUM   = 2'd2,
    ST_LEN   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HEAD_BYTE = 2'd0,
    REG_TAIL_BYTE = 2'd1,
    REG_MAX_LEN   = 2'd2
  } reg_index_t;

  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_VERDICT = 1'b1;

  localparam logic [7:0] MAX_PAYLOAD    = 8'd32;
  localparam logic [7:0] HEAD_BYTE_RST  = 8'd170;
  localparam logic [7:0] TAIL_BYTE_RST  = 8'd85;
  localparam logic [5:0] MAX_LEN_RST    = 6'd32;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_len;
    status_t    status;
    logic       last;
  } result_t;

endpackage

// ===== rtl/core/sum_checked_frame_parser.sv =====
// Top level of the sum-checked frame parser: byte-wise frame state machine
// with a two-entry output stage. Depends on scfp_pkg.
`timescale 1ns / 1ps

// Parses head, type, length, payload, checksum (mod-256 payload sum) and tail
// bytes, one byte per transaction. Every payload byte is forwarded; the tail,
// a wrong head or an over-long length yields a verdict with last set. After a
// verdict bytes are dropped until buffer_start. Throughput is one byte per
// cycle: the frame state updates in the cycle a byte is accepted and the
// result lands in an output register backed by one skid entry, so in_stall
// rises only while both output entries are held by a stalled consumer.
// Each accepted byte's result is registered in out_q, or in the skid entry while out_q is held.
module sum_checked_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       buffer_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] payload_byte,
  output logic [7:0] frame_type,
  output logic [7:0] frame_len,
  output logic [1:0] status,
  output logic       last
);
  import scfp_pkg::*;

  logic [7:0] head_byte;
  logic [7:0] tail_byte;
  logic [5:0] max_len;

  phase_t     phase, phase_next;
  logic [7:0] type_seen, type_seen_next;
  logic [7:0] length_seen, length_seen_next;
  logic [5:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic       sum_matched, sum_matched_next;

  phase_t     cur_phase;
  logic [7:0] cur_type, cur_len, cur_sum;
  logic [5:0] cur_count;
  logic       cur_matched;
  logic [7:0] limit;
  logic [5:0] count_inc;

  logic       res_valid;
  result_t    res;

  result_t    out_q, skid_q;
  logic       skid_valid;
  logic       accept, take;

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~in_stall;
  assign take     = out_valid & ~out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_BYTE_RST;
      tail_byte <= TAIL_BYTE_RST;
      max_len   <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD_BYTE: head_byte <= cfg_data;
        REG_TAIL_BYTE: tail_byte <= cfg_data;
        REG_MAX_LEN:   max_len   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // buffer start restarts the frame
  always_comb begin
    if (buffer_start) begin
      cur_phase   = PH_HEAD;
      cur_type    = 8'd0;
      cur_len     = 8'd0;
      cur_count   = 6'd0;
      cur_sum     = 8'd0;
      cur_matched = 1'b0;
    end else begin
      cur_phase   = phase;
      cur_type    = type_seen;
      cur_len     = length_seen;
      cur_count   = payload_count;
      cur_sum     = running_sum;
      cur_matched = sum_matched;
    end
  end

  assign limit     = (MAX_PAYLOAD < {2'b00, max_len}) ? MAX_PAYLOAD : {2'b00, max_len};
  assign count_inc = cur_count + 6'd1;

  // next state
  always_comb begin
    phase_next         = cur_phase;
    type_seen_next     = cur_type;
    length_seen_next   = cur_len;
    payload_count_next = cur_count;
    running_sum_next   = cur_sum;
    sum_matched_next   = cur_matched;
    unique case (cur_phase)
      PH_HEAD: phase_next = (rx_byte == head_byte) ? PH_TYPE : PH_IDLE;
      PH_TYPE: begin
        type_seen_next = rx_byte;
        phase_next     = PH_LEN;
      end
      PH_LEN: begin
        length_seen_next = rx_byte;
        if (rx_byte > limit) begin
          phase_next = PH_IDLE;
        end else begin
          payload_count_next = 6'd0;
          running_sum_next   = 8'd0;
          phase_next         = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_next   = cur_sum + rx_byte;
        payload_count_next = count_inc;
        if ({2'b00, count_inc} >= cur_len) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        sum_matched_next = (rx_byte == cur_sum);
        phase_next       = PH_TAIL;
      end
      PH_TAIL: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  // result for this byte
  always_comb begin
    res_valid        = 1'b0;
    res.out_kind     = KIND_VERDICT;
    res.payload_byte = 8'd0;
    res.frame_type   = type_seen_next;
    res.frame_len    = length_seen_next;
    res.status       = ST_OK;
    res.last         = 1'b1;
    unique case (cur_phase)
      PH_HEAD: begin
        if (rx_byte != head_byte) begin
          res_valid  = 1'b1;
          res.status = ST_FRAME;
        end
      end
      PH_LEN: begin
        if (rx_byte > limit) begin
          res_valid  = 1'b1;
          res.status = ST_LEN;
        end
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.out_kind     = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.last         = 1'b0;
      end
      PH_TAIL: begin
        res_valid = 1'b1;
        priority if (rx_byte != tail_byte) begin
          res.status = ST_FRAME;
        end else if (!cur_matched) begin
          res.status = ST_SUM;
        end else begin
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      type_seen     <= 8'd0;
      length_seen   <= 8'd0;
      payload_count <= 6'd0;
      running_sum   <= 8'd0;
      sum_matched   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      type_seen     <= type_seen_next;
      length_seen   <= length_seen_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      sum_matched   <= sum_matched_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (!out_valid) begin
        out_valid <= accept & res_valid;
      end else if (take) begin
        if (skid_valid) begin
          skid_valid <= accept & res_valid;
        end else begin
          out_valid <= accept & res_valid;
        end
      end else begin
        if (accept & res_valid) begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (!out_valid || (take && !skid_valid)) begin
      out_q <= res;
    end else if (take) begin
      out_q  <= skid_q;
      skid_q <= res;
    end else begin
      if (!skid_valid) begin
        skid_q <= res;
      end
    end
  end

  assign out_kind     = out_q.out_kind;
  assign payload_byte = out_q.payload_byte;
  assign frame_type   = out_q.frame_type;
  assign frame_len    = out_q.frame_len;
  assign status       = out_q.status;
  assign last         = out_q.last;

endmodule
